// ----- hw/rtl/salr_pkg.sv -----
// Shared constants, codes and handshake types for the stroke arc length resampler.
`default_nettype none

package salr_pkg;

	// Defaults for the top level parameters.
	localparam int MAX_EMITS_DEF = 62;
	localparam int FRAC_BITS_DEF = 16;

	// Field and datapath widths.
	localparam int COORD_W  = 32;
	localparam int PRESS_W  = 17;
	localparam int SCALE_W  = 24;
	localparam int CFG_W    = 32;
	localparam int LEN_W    = 42;
	localparam int POS_W    = 48;
	localparam int ITER_W   = 6;

	// Result buffer depth and its index width.
	localparam int RES_DEPTH = 64;
	localparam int RES_AW    = 6;

	// Spacing register value after reset, unsigned Q16.16.
	localparam logic [CFG_W-1:0] SPACING_RST = 32'h0001_0000;
	localparam logic [SCALE_W-1:0] SCALE_RST = 24'h01_0000;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_SPACING,
		CFG_SCALE_X,
		CFG_SCALE_Z,
		CFG_DUP_THR
	} cfg_idx_t;

	// Request to the distance unit.
	typedef struct packed {
		logic start;
		logic want_len;
	} dist_req_t;

	// Status back from the distance unit.
	typedef struct packed {
		logic done;
		logic dup;
	} dist_rsp_t;

	// One buffered result word.
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] z;
		logic [PRESS_W-1:0] pr;
		logic               last;
	} res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/salr_dist.sv -----
// Bit-serial distance unit: scaled deltas, squared distance, duplicate test and square root.
`default_nettype none

module salr_dist (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire salr_pkg::dist_req_t          req,
	input  wire logic [salr_pkg::COORD_W-1:0] a_x,
	input  wire logic [salr_pkg::COORD_W-1:0] a_z,
	input  wire logic [salr_pkg::COORD_W-1:0] b_x,
	input  wire logic [salr_pkg::COORD_W-1:0] b_z,
	input  wire logic [salr_pkg::SCALE_W-1:0] scale_x,
	input  wire logic [salr_pkg::SCALE_W-1:0] scale_z,
	input  wire logic [salr_pkg::CFG_W-1:0]   dup_thr,
	output salr_pkg::dist_rsp_t               rsp,
	output logic [salr_pkg::LEN_W-1:0]        len
);

	typedef enum logic [2:0] {
		D_IDLE,
		D_MAG,
		D_SQSET,
		D_SQ,
		D_SUM,
		D_ROOT,
		D_DONE
	} dstate_t;

	dstate_t     state_q;
	logic [5:0]  it_q;
	logic        want_q;
	logic        dup_q;
	logic [56:0] mcx_q, mcz_q, px_q, pz_q;
	logic [23:0] sbx_q, sbz_q;
	logic [81:0] sqx_q, sqz_q, sx_q, sz_q;
	logic [40:0] qbx_q, qbz_q;
	logic [83:0] rad_q;
	logic [45:0] rrem_q;
	logic [41:0] root_q;

	logic [32:0] dx, dz, mx, mz;
	logic [82:0] sum;
	logic [45:0] rem2;
	logic [45:0] trial;
	logic        ge;

	always_comb begin
		dx = {b_x[31], b_x} - {a_x[31], a_x};
		dz = {b_z[31], b_z} - {a_z[31], a_z};
		mx = dx[32] ? (~dx + 33'd1) : dx;
		mz = dz[32] ? (~dz + 33'd1) : dz;
		sum = {1'b0, sx_q} + {1'b0, sz_q};
		rem2 = {rrem_q[43:0], rad_q[83:82]};
		trial = {2'b00, root_q, 2'b01};
		ge = rem2 >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			it_q    <= '0;
			want_q  <= 1'b0;
			dup_q   <= 1'b0;
			mcx_q   <= '0;
			mcz_q   <= '0;
			px_q    <= '0;
			pz_q    <= '0;
			sbx_q   <= '0;
			sbz_q   <= '0;
			sqx_q   <= '0;
			sqz_q   <= '0;
			sx_q    <= '0;
			sz_q    <= '0;
			qbx_q   <= '0;
			qbz_q   <= '0;
			rad_q   <= '0;
			rrem_q  <= '0;
			root_q  <= '0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (req.start) begin
						want_q  <= req.want_len;
						mcx_q   <= {24'd0, mx};
						mcz_q   <= {24'd0, mz};
						sbx_q   <= scale_x;
						sbz_q   <= scale_z;
						px_q    <= '0;
						pz_q    <= '0;
						it_q    <= 6'd24;
						state_q <= D_MAG;
					end
				end
				D_MAG: begin
					if (sbx_q[0]) px_q <= px_q + mcx_q;
					if (sbz_q[0]) pz_q <= pz_q + mcz_q;
					mcx_q <= {mcx_q[55:0], 1'b0};
					mcz_q <= {mcz_q[55:0], 1'b0};
					sbx_q <= {1'b0, sbx_q[23:1]};
					sbz_q <= {1'b0, sbz_q[23:1]};
					it_q  <= it_q - 6'd1;
					if (it_q == 6'd1) state_q <= D_SQSET;
				end
				D_SQSET: begin
					// The scaled magnitude is the product shifted down by 16.
					sqx_q   <= {41'd0, px_q[56:16]};
					sqz_q   <= {41'd0, pz_q[56:16]};
					qbx_q   <= px_q[56:16];
					qbz_q   <= pz_q[56:16];
					sx_q    <= '0;
					sz_q    <= '0;
					it_q    <= 6'd41;
					state_q <= D_SQ;
				end
				D_SQ: begin
					if (qbx_q[0]) sx_q <= sx_q + sqx_q;
					if (qbz_q[0]) sz_q <= sz_q + sqz_q;
					sqx_q <= {sqx_q[80:0], 1'b0};
					sqz_q <= {sqz_q[80:0], 1'b0};
					qbx_q <= {1'b0, qbx_q[40:1]};
					qbz_q <= {1'b0, qbz_q[40:1]};
					it_q  <= it_q - 6'd1;
					if (it_q == 6'd1) state_q <= D_SUM;
				end
				D_SUM: begin
					dup_q  <= (px_q[56:32] == '0) && (pz_q[56:32] == '0) &&
						(sum <= {51'd0, dup_thr});
					rad_q  <= {1'b0, sum};
					rrem_q <= '0;
					root_q <= '0;
					it_q   <= 6'd42;
					state_q <= want_q ? D_ROOT : D_DONE;
				end
				D_ROOT: begin
					rrem_q <= ge ? (rem2 - trial) : rem2;
					root_q <= {root_q[40:0], ge};
					rad_q  <= {rad_q[81:0], 2'b00};
					it_q   <= it_q - 6'd1;
					if (it_q == 6'd1) state_q <= D_DONE;
				end
				D_DONE: begin
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = (state_q == D_DONE);
	assign rsp.dup  = dup_q;
	assign len      = root_q;

endmodule

`default_nettype wire

// ----- hw/rtl/stroke_arc_length_resampler.sv -----
// Top level of the stroke arc length resampler: sequencer, serial divider, lerp lanes, buffer.
// Each input word passes through the duplicate test, a length for each closed segment, and a
// divide and an interpolation for each point placed. Results are gathered in a 64-word buffer
// and drained afterwards. One input word is taken at a time; the next is taken once the buffer
// has drained, while the final result may still wait in the output register.
// Reset: asynchronous, active low; clears the stroke state and loads the register defaults.
`default_nettype none

module stroke_arc_length_resampler #(
	parameter int MAX_EMITS_PER_SEGMENT = salr_pkg::MAX_EMITS_DEF,
	parameter int FRAC_BITS             = salr_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Configuration write port.
	input  wire logic                                cfg_wr_en,
	input  wire logic [1:0]                          cfg_index,
	input  wire logic [salr_pkg::CFG_W-1:0]          cfg_wdata,
	// Input sample channel.
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [salr_pkg::COORD_W-1:0] sample_x,
	input  wire logic signed [salr_pkg::COORD_W-1:0] sample_z,
	input  wire logic [salr_pkg::PRESS_W-1:0]        sample_pressure,
	input  wire logic                                stroke_last,
	// Result channel.
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [salr_pkg::COORD_W-1:0]      out_x,
	output logic signed [salr_pkg::COORD_W-1:0]      out_z,
	output logic [salr_pkg::PRESS_W-1:0]             out_pressure,
	output logic                                     run_last,
	output logic                                     stroke_end,
	output logic                                     overflow
);

	localparam int BW  = $clog2(MAX_EMITS_PER_SEGMENT + 1);
	localparam int XLW = salr_pkg::COORD_W + 1 + FRAC_BITS;
	localparam int PLW = salr_pkg::PRESS_W + FRAC_BITS;
	localparam int CW  = salr_pkg::COORD_W;
	localparam int PW  = salr_pkg::PRESS_W;

	// The sequencer walks one input word through the duplicate test, up to two segment
	// closes, the stroke end handling, and finally the drain of the result buffer.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHK,
		ST_DUPW,
		ST_SETP,
		ST_SEGL,
		ST_SEGW,
		ST_LOOP,
		ST_TDIV,
		ST_LSET,
		ST_LERP,
		ST_LEMIT,
		ST_SKIPW,
		ST_SEGE,
		ST_HCHK,
		ST_HDUPW,
		ST_FINP,
		ST_RD,
		ST_LOAD
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [31:0] spacing_q;
	logic [23:0] scale_x_q, scale_z_q;
	logic [31:0] dup_thr_q;

	// Latched input word.
	logic [CW-1:0] s_x_q, s_z_q;
	logic [PW-1:0] s_pr_q;
	logic          s_last_q;

	// Stroke state: newest sample, segment start and the emission held back by one.
	logic          pend_v_q, anc_v_q, held_v_q;
	logic [CW-1:0] pend_x_q, pend_z_q, anc_x_q, anc_z_q, held_x_q, held_z_q;
	logic [PW-1:0] pend_pr_q, anc_pr_q, held_pr_q;
	logic [47:0]   trav_q, nmark_q, end_q;
	logic [41:0]   len_q;

	// Per word bookkeeping.
	logic [BW-1:0] budget_q;
	logic          skip_q;
	logic          seg_fin_q;
	logic [6:0]    wcnt_q;
	logic [5:0]    rd_ptr_q;
	logic [5:0]    it_q;

	// Serial divider, shared by the fraction and the skip count.
	logic [42:0]          rem_q;
	logic [47:0]          dsh_q;
	logic [FRAC_BITS-1:0] quo_q;

	// Interpolation lanes for x, z and pressure.
	logic                 lx_neg_q, lz_neg_q, lp_neg_q;
	logic [XLW-1:0]       lx_mc_q, lx_acc_q, lz_mc_q, lz_acc_q;
	logic [PLW-1:0]       lp_mc_q, lp_acc_q;
	logic [FRAC_BITS-1:0] tsh_q;

	// Result buffer.
	salr_pkg::res_t buf_mem [salr_pkg::RES_DEPTH];
	salr_pkg::res_t rd_data_q;

	// Distance unit.
	salr_pkg::dist_req_t dist_req;
	salr_pkg::dist_rsp_t dist_rsp;
	logic [41:0]         dist_len;
	logic [CW-1:0]       da_x, da_z, db_x, db_z;

	// Combinational helpers.
	logic [31:0] sp_eff;
	logic [47:0] sp_ext;
	logic [47:0] num;
	logic        mark_in;
	logic [43:0] div_tr, div_dv;
	logic        div_ge;
	logic [42:0] rem_n;
	logic [32:0] dxl, dzl, mxl, mzl;
	logic [17:0] dpl;
	logic [16:0] mpl;
	logic [32:0] offx, offz;
	logic [16:0] offp;
	logic [32:0] resx, resz;
	logic [16:0] resp;
	logic          emit_en;
	logic [CW-1:0] emit_x, emit_z;
	logic [PW-1:0] emit_pr;
	logic           wr_en;
	salr_pkg::res_t wr_data;
	logic           out_free;
	logic           rd_fire;

	always_comb begin
		// A spacing of zero behaves as the smallest step.
		sp_eff  = (spacing_q == '0) ? 32'd1 : spacing_q;
		sp_ext  = {16'd0, sp_eff};
		num     = nmark_q - trav_q;
		mark_in = nmark_q <= end_q;

		div_tr = {rem_q, dsh_q[47]};
		div_dv = (state_q == ST_SKIPW) ? {12'd0, sp_eff} : {2'd0, len_q};
		div_ge = div_tr >= div_dv;
		rem_n  = div_ge ? 43'(div_tr - div_dv) : div_tr[42:0];

		dxl = {pend_x_q[31], pend_x_q} - {anc_x_q[31], anc_x_q};
		dzl = {pend_z_q[31], pend_z_q} - {anc_z_q[31], anc_z_q};
		dpl = {1'b0, pend_pr_q} - {1'b0, anc_pr_q};
		mxl = dxl[32] ? (~dxl + 33'd1) : dxl;
		mzl = dzl[32] ? (~dzl + 33'd1) : dzl;
		mpl = dpl[17] ? 17'(~dpl + 18'd1) : dpl[16:0];

		offx = lx_acc_q[FRAC_BITS +: 33];
		offz = lz_acc_q[FRAC_BITS +: 33];
		offp = lp_acc_q[FRAC_BITS +: 17];
		resx = lx_neg_q ? ({1'b0, anc_x_q} - offx) : ({1'b0, anc_x_q} + offx);
		resz = lz_neg_q ? ({1'b0, anc_z_q} - offz) : ({1'b0, anc_z_q} + offz);
		resp = lp_neg_q ? (anc_pr_q - offp) : (anc_pr_q + offp);

		// A new emission pushes the held one into the buffer.
		emit_en = 1'b0;
		emit_x  = pend_x_q;
		emit_z  = pend_z_q;
		emit_pr = pend_pr_q;
		case (state_q)
			ST_DUPW: emit_en = dist_rsp.done && !dist_rsp.dup && !anc_v_q;
			ST_LOOP: emit_en = mark_in && (budget_q != '0) && (num >= {6'd0, len_q});
			ST_LEMIT: begin
				emit_en = 1'b1;
				emit_x  = resx[31:0];
				emit_z  = resz[31:0];
				emit_pr = resp;
			end
			default: emit_en = 1'b0;
		endcase

		wr_data.x    = held_x_q;
		wr_data.z    = held_z_q;
		wr_data.pr   = held_pr_q;
		wr_data.last = 1'b0;
		wr_en        = 1'b0;
		case (state_q)
			ST_HDUPW: wr_en = dist_rsp.done && !dist_rsp.dup;
			ST_FINP: begin
				wr_en        = 1'b1;
				wr_data.x    = pend_x_q;
				wr_data.z    = pend_z_q;
				wr_data.pr   = pend_pr_q;
				wr_data.last = 1'b1;
			end
			default: wr_en = emit_en && held_v_q;
		endcase
		wr_en = wr_en && !wcnt_q[6];

		da_x = pend_x_q;
		da_z = pend_z_q;
		db_x = s_x_q;
		db_z = s_z_q;
		dist_req.start    = 1'b0;
		dist_req.want_len = 1'b0;
		case (state_q)
			ST_CHK: dist_req.start = pend_v_q;
			ST_SEGL: begin
				da_x = anc_x_q;
				da_z = anc_z_q;
				db_x = pend_x_q;
				db_z = pend_z_q;
				dist_req.start    = 1'b1;
				dist_req.want_len = 1'b1;
			end
			ST_HCHK: begin
				da_x = held_x_q;
				da_z = held_z_q;
				db_x = pend_x_q;
				db_z = pend_z_q;
				dist_req.start = held_v_q;
			end
			default: dist_req.start = 1'b0;
		endcase

		out_free = !out_valid || out_ready;
		rd_fire  = (state_q == ST_RD) && out_free;
	end

	salr_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (dist_req),
		.a_x     (da_x),
		.a_z     (da_z),
		.b_x     (db_x),
		.b_z     (db_z),
		.scale_x (scale_x_q),
		.scale_z (scale_z_q),
		.dup_thr (dup_thr_q),
		.rsp     (dist_rsp),
		.len     (dist_len)
	);

	always_ff @(posedge clk) begin
		if (wr_en) buf_mem[wcnt_q[5:0]] <= wr_data;
		if (rd_fire) rd_data_q <= buf_mem[rd_ptr_q];
	end

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			spacing_q    <= salr_pkg::SPACING_RST;
			scale_x_q    <= salr_pkg::SCALE_RST;
			scale_z_q    <= salr_pkg::SCALE_RST;
			dup_thr_q    <= '0;
			s_x_q        <= '0;
			s_z_q        <= '0;
			s_pr_q       <= '0;
			s_last_q     <= 1'b0;
			pend_v_q     <= 1'b0;
			anc_v_q      <= 1'b0;
			held_v_q     <= 1'b0;
			pend_x_q     <= '0;
			pend_z_q     <= '0;
			pend_pr_q    <= '0;
			anc_x_q      <= '0;
			anc_z_q      <= '0;
			anc_pr_q     <= '0;
			held_x_q     <= '0;
			held_z_q     <= '0;
			held_pr_q    <= '0;
			trav_q       <= '0;
			nmark_q      <= {16'd0, salr_pkg::SPACING_RST};
			end_q        <= '0;
			len_q        <= '0;
			budget_q     <= '0;
			skip_q       <= 1'b0;
			seg_fin_q    <= 1'b0;
			wcnt_q       <= '0;
			rd_ptr_q     <= '0;
			it_q         <= '0;
			rem_q        <= '0;
			dsh_q        <= '0;
			quo_q        <= '0;
			lx_neg_q     <= 1'b0;
			lz_neg_q     <= 1'b0;
			lp_neg_q     <= 1'b0;
			lx_mc_q      <= '0;
			lx_acc_q     <= '0;
			lz_mc_q      <= '0;
			lz_acc_q     <= '0;
			lp_mc_q      <= '0;
			lp_acc_q     <= '0;
			tsh_q        <= '0;
			out_valid    <= 1'b0;
			out_x        <= '0;
			out_z        <= '0;
			out_pressure <= '0;
			run_last     <= 1'b0;
			stroke_end   <= 1'b0;
			overflow     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					salr_pkg::CFG_SPACING: spacing_q <= cfg_wdata;
					salr_pkg::CFG_SCALE_X: scale_x_q <= cfg_wdata[23:0];
					salr_pkg::CFG_SCALE_Z: scale_z_q <= cfg_wdata[23:0];
					salr_pkg::CFG_DUP_THR: dup_thr_q <= cfg_wdata;
					default: dup_thr_q <= dup_thr_q;
				endcase
			end

			if (out_valid && out_ready) out_valid <= 1'b0;

			if (wr_en) wcnt_q <= wcnt_q + 7'd1;

			if (emit_en) begin
				held_x_q  <= emit_x;
				held_z_q  <= emit_z;
				held_pr_q <= emit_pr;
				held_v_q  <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						s_x_q    <= sample_x;
						s_z_q    <= sample_z;
						s_pr_q   <= sample_pressure;
						s_last_q <= stroke_last;
						budget_q <= BW'(MAX_EMITS_PER_SEGMENT);
						skip_q   <= 1'b0;
						wcnt_q   <= '0;
						state_q  <= ST_CHK;
					end
				end
				ST_CHK: begin
					state_q <= pend_v_q ? ST_DUPW : ST_SETP;
				end
				ST_DUPW: begin
					if (dist_rsp.done) begin
						if (dist_rsp.dup) begin
							state_q <= ST_SETP;
						end else if (!anc_v_q) begin
							// First distinct sample of the stroke opens the arc.
							anc_v_q  <= 1'b1;
							trav_q   <= '0;
							nmark_q  <= sp_ext;
							anc_x_q  <= pend_x_q;
							anc_z_q  <= pend_z_q;
							anc_pr_q <= pend_pr_q;
							state_q  <= ST_SETP;
						end else begin
							seg_fin_q <= 1'b0;
							state_q   <= ST_SEGL;
						end
					end
				end
				ST_SETP: begin
					pend_x_q  <= s_x_q;
					pend_z_q  <= s_z_q;
					pend_pr_q <= s_pr_q;
					pend_v_q  <= 1'b1;
					if (s_last_q) begin
						if (anc_v_q) begin
							seg_fin_q <= 1'b1;
							state_q   <= ST_SEGL;
						end else begin
							state_q <= ST_FINP;
						end
					end else if (wcnt_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						rd_ptr_q <= '0;
						state_q  <= ST_RD;
					end
				end
				ST_SEGL: begin
					state_q <= ST_SEGW;
				end
				ST_SEGW: begin
					if (dist_rsp.done) begin
						len_q   <= dist_len;
						end_q   <= trav_q + {6'd0, dist_len};
						state_q <= ST_LOOP;
					end
				end
				ST_LOOP: begin
					if (!mark_in) begin
						state_q <= ST_SEGE;
					end else if (budget_q == '0) begin
						// Out of budget: jump the mark past the segment end.
						rem_q   <= '0;
						dsh_q   <= end_q - nmark_q;
						it_q    <= 6'd48;
						state_q <= ST_SKIPW;
					end else begin
						budget_q <= budget_q - BW'(1);
						if (num >= {6'd0, len_q}) begin
							nmark_q <= nmark_q + sp_ext;
						end else begin
							rem_q   <= num[42:0];
							dsh_q   <= '0;
							it_q    <= 6'(FRAC_BITS);
							state_q <= ST_TDIV;
						end
					end
				end
				ST_TDIV: begin
					rem_q <= rem_n;
					dsh_q <= {dsh_q[46:0], 1'b0};
					quo_q <= {quo_q[FRAC_BITS-2:0], div_ge};
					it_q  <= it_q - 6'd1;
					if (it_q == 6'd1) state_q <= ST_LSET;
				end
				ST_LSET: begin
					tsh_q    <= quo_q;
					lx_neg_q <= dxl[32];
					lz_neg_q <= dzl[32];
					lp_neg_q <= dpl[17];
					lx_mc_q  <= XLW'(mxl);
					lz_mc_q  <= XLW'(mzl);
					lp_mc_q  <= PLW'(mpl);
					lx_acc_q <= '0;
					lz_acc_q <= '0;
					lp_acc_q <= '0;
					it_q     <= 6'(FRAC_BITS);
					state_q  <= ST_LERP;
				end
				ST_LERP: begin
					if (tsh_q[0]) begin
						lx_acc_q <= lx_acc_q + lx_mc_q;
						lz_acc_q <= lz_acc_q + lz_mc_q;
						lp_acc_q <= lp_acc_q + lp_mc_q;
					end
					lx_mc_q <= {lx_mc_q[XLW-2:0], 1'b0};
					lz_mc_q <= {lz_mc_q[XLW-2:0], 1'b0};
					lp_mc_q <= {lp_mc_q[PLW-2:0], 1'b0};
					tsh_q   <= {1'b0, tsh_q[FRAC_BITS-1:1]};
					it_q    <= it_q - 6'd1;
					if (it_q == 6'd1) state_q <= ST_LEMIT;
				end
				ST_LEMIT: begin
					nmark_q <= nmark_q + sp_ext;
					state_q <= ST_LOOP;
				end
				ST_SKIPW: begin
					rem_q <= rem_n;
					dsh_q <= {dsh_q[46:0], 1'b0};
					it_q  <= it_q - 6'd1;
					if (it_q == 6'd1) begin
						nmark_q <= end_q - {5'd0, rem_n} + sp_ext;
						skip_q  <= 1'b1;
						state_q <= ST_SEGE;
					end
				end
				ST_SEGE: begin
					// Lower both positions together once the arc gets long.
					if (end_q[47:46] != 2'b00) begin
						nmark_q <= nmark_q - end_q;
						trav_q  <= '0;
					end else begin
						trav_q <= end_q;
					end
					if (seg_fin_q) begin
						state_q <= ST_HCHK;
					end else begin
						anc_x_q  <= pend_x_q;
						anc_z_q  <= pend_z_q;
						anc_pr_q <= pend_pr_q;
						state_q  <= ST_SETP;
					end
				end
				ST_HCHK: begin
					state_q <= held_v_q ? ST_HDUPW : ST_FINP;
				end
				ST_HDUPW: begin
					if (dist_rsp.done) state_q <= ST_FINP;
				end
				ST_FINP: begin
					pend_v_q <= 1'b0;
					anc_v_q  <= 1'b0;
					held_v_q <= 1'b0;
					trav_q   <= '0;
					nmark_q  <= sp_ext;
					rd_ptr_q <= '0;
					state_q  <= ST_RD;
				end
				ST_RD: begin
					if (out_free) state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					out_valid    <= 1'b1;
					out_x        <= rd_data_q.x;
					out_z        <= rd_data_q.z;
					out_pressure <= rd_data_q.pr;
					stroke_end   <= rd_data_q.last;
					overflow     <= skip_q;
					run_last     <= ({1'b0, rd_ptr_q} + 7'd1) == wcnt_q;
					rd_ptr_q     <= rd_ptr_q + 6'd1;
					if (({1'b0, rd_ptr_q} + 7'd1) == wcnt_q) state_q <= ST_IDLE;
					else state_q <= ST_RD;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The buffer never takes more words than it holds.
	a_wcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wcnt_q <= 7'(salr_pkg::RES_DEPTH))
		else $error("result buffer count out of range");

	// A held emission only exists inside an open segment.
	a_held_anchor: assert property (@(posedge clk) disable iff (!arst_n)
		held_v_q |-> anc_v_q)
		else $error("held emission without anchor");

	// The distance unit only answers while the sequencer waits for it.
	a_dist_wait: assert property (@(posedge clk) disable iff (!arst_n)
		dist_rsp.done |-> (state_q == ST_DUPW || state_q == ST_SEGW || state_q == ST_HDUPW))
		else $error("distance result arrived unexpectedly");

	// Drain reads stay within the words written.
	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> ({1'b0, rd_ptr_q} < wcnt_q))
		else $error("drain read beyond buffer fill");

	// The final word of an input is the only one that can close a drain.
	a_load_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && $past(state_q) == ST_RD) |=> (run_last == (state_q == ST_IDLE)))
		else $error("run_last disagrees with drain end");

endmodule

`default_nettype wire
